// ===== rtl/lsm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lsm_pkg: shared types and constants of the line substring matcher
// Register indexes, configuration record, queue entry and the case fold.
// ----------------------------------------------------------------------------
package lsm_pkg;

   localparam int MAX_PATTERN_DEF = 32;   // default window depth
   localparam int PATTERN_BYTES   = 32;   // bytes held by the pattern registers
   localparam int PATTERN_WORDS   = 4;
   localparam int WORD_W          = 64;
   localparam int PB_IDX_W        = $clog2(PATTERN_BYTES);
   localparam int LEN_REG_W       = 6;
   localparam int WIDE_W          = LEN_REG_W + 1;   // holds lengths up to 127
   localparam int CSR_IDX_W       = 3;
   localparam int QUEUE_DEPTH     = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IGNORE_CASE    = 3'd0,
      CSR_PATTERN_LENGTH = 3'd1,
      CSR_PATTERN_WORD0  = 3'd2,
      CSR_PATTERN_WORD1  = 3'd3,
      CSR_PATTERN_WORD2  = 3'd4,
      CSR_PATTERN_WORD3  = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic                                ignore_case;
      logic [LEN_REG_W-1:0]                pattern_length;
      logic [PATTERN_WORDS-1:0][WORD_W-1:0] pattern_words;
   } lsm_cfg_type;

   typedef struct packed {
      logic hit;
      logic eol;
   } lsm_item_type;

   function automatic logic [7:0] fold_byte(input logic icase, input logic [7:0] c);
      if (icase && (c >= 8'h41) && (c <= 8'h5A)) begin
         return c + 8'h20;
      end
      return c;
   endfunction

endpackage : lsm_pkg
`default_nettype wire

// ===== rtl/lsm_req_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lsm_req_if: text byte channel
// One text byte and its end-of-line mark per item.
// ----------------------------------------------------------------------------
interface lsm_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_byte;
   logic       end_of_line;

   modport source (output valid, output char_byte, output end_of_line, input ready);
   modport sink   (input valid, input char_byte, input end_of_line, output ready);
endinterface : lsm_req_if
`default_nettype wire

// ===== rtl/lsm_rsp_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lsm_rsp_if: line result channel
// One match flag per finished line.
// ----------------------------------------------------------------------------
interface lsm_rsp_if;
   logic valid;
   logic ready;
   logic line_matched;

   modport source (output valid, output line_matched, input ready);
   modport sink   (input valid, input line_matched, output ready);
endinterface : lsm_rsp_if
`default_nettype wire

// ===== rtl/lsm_csr_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lsm_csr_if: configuration write channel
// Register index and write data per item.
// ----------------------------------------------------------------------------
interface lsm_csr_if
   import lsm_pkg::*;
;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] reg_index;
   logic [WORD_W-1:0]    wr_data;

   modport source (output valid, output reg_index, output wr_data, input ready);
   modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface : lsm_csr_if
`default_nettype wire

// ===== rtl/lsm_csr.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lsm_csr: configuration registers
// Decode writes into the ignore-case flag, pattern length and pattern words.
// ----------------------------------------------------------------------------
module lsm_csr
   import lsm_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 wr_valid,
   output      logic                 wr_ready,
   input  wire logic [CSR_IDX_W-1:0] wr_index,
   input  wire logic [WORD_W-1:0]    wr_data,
   output      lsm_cfg_type          cfg
);

   lsm_cfg_type cfg_ff;
   lsm_cfg_type cfg_in;

   assign wr_ready = 1'b1;
   assign cfg      = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_valid) begin
         unique case (wr_index)
            CSR_IGNORE_CASE:    cfg_in.ignore_case      = wr_data[0];
            CSR_PATTERN_LENGTH: cfg_in.pattern_length   = wr_data[LEN_REG_W-1:0];
            CSR_PATTERN_WORD0:  cfg_in.pattern_words[0] = wr_data;
            CSR_PATTERN_WORD1:  cfg_in.pattern_words[1] = wr_data;
            CSR_PATTERN_WORD2:  cfg_in.pattern_words[2] = wr_data;
            CSR_PATTERN_WORD3:  cfg_in.pattern_words[3] = wr_data;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule : lsm_csr
`default_nettype wire

// ===== rtl/lsm_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lsm_front: window and compare stage
// Shift each byte into the window register, then compare the window with the
// aligned pattern in the next cycle and emit a hit/end-of-line item.
// ----------------------------------------------------------------------------
module lsm_front
   import lsm_pkg::*;
#(
   parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire lsm_cfg_type  cfg,
   input  wire logic         in_valid,
   output      logic         in_ready,
   input  wire logic [7:0]   in_char,
   input  wire logic         in_eol,
   output      logic         push_valid,
   input  wire logic         push_ready,
   output      lsm_item_type push_item
);

   localparam int LEN_W = $clog2(MAX_PATTERN + 1);

   logic [MAX_PATTERN-1:0][7:0] win_ff, win_in;
   logic [MAX_PATTERN-1:0][7:0] aligned_ff, aligned_in;
   logic [MAX_PATTERN-1:0]      mask_ff, mask_in;
   logic [MAX_PATTERN-1:0]      eq;
   logic [LEN_W-1:0]            len_ff, len_in;
   logic [LEN_W-1:0]            cnt_ff, cnt_in, cnt_inc;
   logic [LEN_W-1:0]            s1_cnt_ff, s1_cnt_in;
   logic                        s1_valid_ff, s1_valid_in;
   logic                        s1_eol_ff, s1_eol_in;
   logic [PATTERN_WORDS*WORD_W-1:0] pat_flat;
   logic [WIDE_W-1:0]           pos;
   logic [7:0]                  pbyte;
   logic                        accept;

   assign pat_flat = cfg.pattern_words;
   assign in_ready = !s1_valid_ff || push_ready;
   assign accept   = in_valid && in_ready;

   // Clamp the length and line the pattern up with the window, newest byte first.
   always_comb begin
      pos   = '0;
      pbyte = '0;
      if ({1'b0, cfg.pattern_length} > WIDE_W'(MAX_PATTERN)) begin
         len_in = LEN_W'(MAX_PATTERN);
      end else begin
         len_in = LEN_W'(cfg.pattern_length);
      end
      for (int j = 0; j < MAX_PATTERN; j++) begin
         pos = WIDE_W'(len_in) - WIDE_W'(j) - WIDE_W'(1);
         if (pos < WIDE_W'(PATTERN_BYTES)) begin
            pbyte = pat_flat[pos[PB_IDX_W-1:0]*8 +: 8];
         end else begin
            pbyte = 8'h00;
         end
         aligned_in[j] = fold_byte(cfg.ignore_case, pbyte);
         mask_in[j]    = WIDE_W'(j) < WIDE_W'(len_in);
      end
   end

   always_comb begin
      win_in[0] = accept ? in_char : win_ff[0];
      for (int j = 1; j < MAX_PATTERN; j++) begin
         win_in[j] = accept ? win_ff[j-1] : win_ff[j];
      end
   end

   assign cnt_inc = (cnt_ff == LEN_W'(MAX_PATTERN)) ? cnt_ff : cnt_ff + LEN_W'(1);

   always_comb begin
      cnt_in      = cnt_ff;
      s1_cnt_in   = s1_cnt_ff;
      s1_eol_in   = s1_eol_ff;
      s1_valid_in = s1_valid_ff;
      if (in_ready) begin
         s1_valid_in = in_valid;
      end
      if (accept) begin
         cnt_in    = in_eol ? '0 : cnt_inc;
         s1_cnt_in = cnt_inc;
         s1_eol_in = in_eol;
      end
   end

   always_comb begin
      for (int j = 0; j < MAX_PATTERN; j++) begin
         eq[j] = (fold_byte(cfg.ignore_case, win_ff[j]) == aligned_ff[j]) || !mask_ff[j];
      end
   end

   assign push_valid    = s1_valid_ff;
   assign push_item.hit = (s1_cnt_ff >= len_ff) && (&eq);
   assign push_item.eol = s1_eol_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff      <= '0;
         cnt_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         win_ff      <= win_in;
         cnt_ff      <= cnt_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      aligned_ff <= aligned_in;
      mask_ff    <= mask_in;
      len_ff     <= len_in;
      s1_cnt_ff  <= s1_cnt_in;
      s1_eol_ff  <= s1_eol_in;
   end

endmodule : lsm_front
`default_nettype wire

// ===== rtl/lsm_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lsm_queue: short item queue
// Decouple the compare stage from the line result logic.
// ----------------------------------------------------------------------------
module lsm_queue
   import lsm_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push_valid,
   output      logic         push_ready,
   input  wire lsm_item_type push_item,
   output      logic         pop_valid,
   input  wire logic         pop_ready,
   output      lsm_item_type pop_item
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   lsm_item_type [QUEUE_DEPTH-1:0] slot_ff;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = count_ff != CNT_W'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_item   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule : lsm_queue
`default_nettype wire

// ===== rtl/lsm_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lsm_back: line result stage
// Collect hits into a per-line flag and register one result per line end.
// ----------------------------------------------------------------------------
module lsm_back
   import lsm_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         pop_valid,
   output      logic         pop_ready,
   input  wire lsm_item_type pop_item,
   output      logic         out_valid,
   input  wire logic         out_ready,
   output      logic         out_matched
);

   logic found_ff, found_in;
   logic valid_ff, valid_in;
   logic matched_ff, matched_in;
   logic do_pop;

   // A non-final byte always drains; a line end waits for a free result slot.
   assign pop_ready   = !pop_item.eol || !valid_ff || out_ready;
   assign do_pop      = pop_valid && pop_ready;
   assign out_valid   = valid_ff;
   assign out_matched = matched_ff;

   always_comb begin
      found_in   = found_ff;
      valid_in   = valid_ff && !out_ready;
      matched_in = matched_ff;
      if (do_pop) begin
         if (pop_item.eol) begin
            found_in   = 1'b0;
            valid_in   = 1'b1;
            matched_in = found_ff || pop_item.hit;
         end else begin
            found_in = found_ff || pop_item.hit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      matched_ff <= matched_in;
   end

endmodule : lsm_back
`default_nettype wire

// ===== rtl/line_substring_matcher.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// line_substring_matcher: per-line substring search over a byte stream
//  - req_chan carries one text byte per item with an end-of-line mark; the
//    marked byte belongs to the line it closes.
//  - rsp_chan returns one item per line end: line_matched is 1 when the
//    configured pattern occurred anywhere in that line (an empty pattern
//    matches every line). Bytes without the mark return nothing.
//  - csr_chan writes ignore_case (0), pattern_length (1) and pattern words
//    0 to 3 (2 to 5); unused indexes are accepted and dropped. Write only
//    while no item is in flight; csr_chan.ready is always high.
//  - Throughput: one byte per cycle unless a stalled rsp_chan backs up the
//    queue. The compare of the whole window against the length-aligned
//    pattern is done as parallel byte compares.
//  - Path: a line-end byte goes through the window shift, the compare into
//    the queue and the result register before its result shows.
//  - Stalls: a two-entry queue sits between compare and result logic; when
//    rsp_chan stalls, non-final bytes drain until a line end heads the queue,
//    and req_chan.ready drops only once the queue and compare stage are full.
//  - Reset (synchronous, active high) clears registers, window, byte count,
//    line flag and queue; no clearing pass is needed.
// ----------------------------------------------------------------------------
module line_substring_matcher
   import lsm_pkg::*;
#(
   parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
   input wire logic clock,
   input wire logic reset,
   lsm_req_if.sink   req_chan,
   lsm_rsp_if.source rsp_chan,
   lsm_csr_if.sink   csr_chan
);

   lsm_cfg_type  cfg;
   logic         push_valid, push_ready;
   lsm_item_type push_item;
   logic         pop_valid, pop_ready;
   lsm_item_type pop_item;

   // Hold the configuration registers.
   lsm_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (csr_chan.valid),
      .wr_ready (csr_chan.ready),
      .wr_index (csr_chan.reg_index),
      .wr_data  (csr_chan.wr_data),
      .cfg      (cfg)
   );

   // Shift bytes into the window and classify each byte as hit or miss.
   lsm_front #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .in_valid   (req_chan.valid),
      .in_ready   (req_chan.ready),
      .in_char    (req_chan.char_byte),
      .in_eol     (req_chan.end_of_line),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   // Buffer classified items so each side can stall on its own.
   lsm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   // Accumulate hits per line and deliver one result at each line end.
   lsm_back u_back (
      .clock       (clock),
      .reset       (reset),
      .pop_valid   (pop_valid),
      .pop_ready   (pop_ready),
      .pop_item    (pop_item),
      .out_valid   (rsp_chan.valid),
      .out_ready   (rsp_chan.ready),
      .out_matched (rsp_chan.line_matched)
   );

endmodule : line_substring_matcher
`default_nettype wire

// ===== test/line_substring_matcher_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_substring_matcher_tb: self-checking bench for the line substring matcher
// Streams text lines through the byte channel under random sender bursts and
// receiver stalls, predicts each line verdict from a scoreboard copy of the
// search window and pattern registers, and checks every line result in order.
// ----------------------------------------------------------------------------
module line_substring_matcher_tb
   import lsm_pkg::*;
;

   localparam int MAX_PAT       = MAX_PATTERN_DEF;
   localparam int RANDOM_ITEMS  = 1450;
   localparam int SETTLE_CYCLES = 8;
   localparam int LONG_HOLD     = 400;
   localparam int CYCLE_LIMIT   = 200000;

   // Indexes past the last register: the block takes the write and drops it.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   typedef struct {
      logic [7:0] char_byte;
      logic       end_of_line;
   } text_byte_type;

   logic clock = 1'b0;
   logic reset;

   lsm_req_if req_bus ();
   lsm_rsp_if rsp_bus ();
   lsm_csr_if csr_bus ();

   line_substring_matcher dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   always #6 clock = ~clock;

   // Bytes waiting to go out, and line verdicts waiting to come back.
   text_byte_type text_q[$];
   logic          line_verdicts_q[$];

   // Scoreboard copy of the registers and of the line scan state.
   lsm_cfg_type cfg_model = '0;
   logic [7:0]  window_bytes [MAX_PAT] = '{default: 8'h00};
   int          line_fill = 0;
   logic        line_hit = 1'b0;

   // Pattern bytes that the stimulus is about to load.
   logic [7:0]  pat_bytes [MAX_PAT] = '{default: 8'h00};

   int   error_count = 0;
   int   cycle_count = 0;
   logic byte_taken = 1'b0;
   logic expected_match;

   // Sender burst/gap state.
   int gap_left = 0;
   int burst_left = 0;

   // Receiver stall state; the long hold is requested from the stimulus side.
   int stall_left = 0;
   int stall_pct = 0;
   int hold_left = 0;
   int hold_requests = 0;
   int holds_served = 0;

   // -------------------------------------------------------------------------
   // Scoreboard model
   // -------------------------------------------------------------------------

   function automatic logic [7:0] fold_letter(input logic [7:0] c);
      if (cfg_model.ignore_case && c >= "A" && c <= "Z") begin
         return c + 8'h20;
      end
      return c;
   endfunction

   // Shift one byte into the window, compare the newest bytes against the
   // pattern and, on a line end, queue the verdict and clear the line state.
   task automatic scan_text_byte(input logic [7:0] c, input logic eol);
      int   len;
      int   k;
      logic hit;
      len = (cfg_model.pattern_length > MAX_PAT) ? MAX_PAT : cfg_model.pattern_length;
      for (k = MAX_PAT - 1; k > 0; k--) begin
         window_bytes[k] = window_bytes[k - 1];
      end
      window_bytes[0] = c;
      if (line_fill < MAX_PAT) begin
         line_fill++;
      end
      if (len == 0) begin
         line_hit = 1'b1;
      end else if (line_fill >= len) begin
         hit = 1'b1;
         // Oldest window byte lines up with pattern byte 0.
         for (k = 0; k < len; k++) begin
            if (fold_letter(window_bytes[len - 1 - k]) !=
                fold_letter(cfg_model.pattern_words[k / 8][(k % 8) * 8 +: 8])) begin
               hit = 1'b0;
            end
         end
         if (hit) begin
            line_hit = 1'b1;
         end
      end
      if (eol) begin
         line_verdicts_q.push_back(line_hit);
         line_fill = 0;
         line_hit = 1'b0;
      end
   endtask

   // -------------------------------------------------------------------------
   // Stimulus helpers
   // -------------------------------------------------------------------------

   task automatic push_byte(input logic [7:0] c, input logic eol);
      text_byte_type item;
      item.char_byte = c;
      item.end_of_line = eol;
      text_q.push_back(item);
   endtask

   task automatic push_text(input string s, input logic close);
      int i;
      for (i = 0; i < s.len(); i++) begin
         push_byte(s[i], close && (i == s.len() - 1));
      end
   endtask

   task automatic set_pattern(input string s);
      int i;
      for (i = 0; i < MAX_PAT; i++) begin
         pat_bytes[i] = (i < s.len()) ? s[i] : 8'h00;
      end
   endtask

   function automatic logic [WORD_W-1:0] pack_word(input int w);
      logic [WORD_W-1:0] word;
      int                i;
      for (i = 0; i < 8; i++) begin
         word[i * 8 +: 8] = pat_bytes[w * 8 + i];
      end
      return word;
   endfunction

   // About half the bytes come from the pattern so that partial hits are common.
   function automatic logic [7:0] noise_byte(input int elen);
      if (elen > 0 && $urandom_range(0, 1) == 1) begin
         return pat_bytes[$urandom_range(0, elen - 1)];
      end
      return 8'($urandom_range(0, 255));
   endfunction

   // Hold until every byte is taken and every verdict is back, then let the
   // pipeline empty out.
   task automatic wait_drained();
      while (text_q.size() != 0 || line_verdicts_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
      @(negedge clock);
      csr_bus.valid     <= 1'b1;
      csr_bus.reg_index <= idx;
      csr_bus.wr_data   <= data;
      @(posedge clock);
      while (!csr_bus.ready) begin
         @(posedge clock);
      end
      case (idx)
         CSR_IGNORE_CASE:    cfg_model.ignore_case = data[0];
         CSR_PATTERN_LENGTH: cfg_model.pattern_length = data[LEN_REG_W-1:0];
         CSR_PATTERN_WORD0:  cfg_model.pattern_words[0] = data;
         CSR_PATTERN_WORD1:  cfg_model.pattern_words[1] = data;
         CSR_PATTERN_WORD2:  cfg_model.pattern_words[2] = data;
         CSR_PATTERN_WORD3:  cfg_model.pattern_words[3] = data;
         default: ;
      endcase
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // Load all registers, the pattern words from pat_bytes; unused upper data bits carry noise.
   task automatic configure(input logic icase, input logic [LEN_REG_W-1:0] plen);
      logic [WORD_W-1:0] junk;
      int                w;
      wait_drained();
      junk = {$urandom, $urandom};
      write_reg(CSR_IGNORE_CASE, {junk[WORD_W-1:1], icase});
      write_reg(CSR_PATTERN_LENGTH, {junk[WORD_W-1:LEN_REG_W], plen});
      for (w = 0; w < PATTERN_WORDS; w++) begin
         write_reg(CSR_IDX_W'(CSR_PATTERN_WORD0 + w), pack_word(w));
      end
   endtask

   // Build one closed line: random lead-in, usually a copy of the pattern
   // (case flipped at random when folding, sometimes corrupted), random tail.
   task automatic queue_random_line(output int count);
      logic [7:0] line_buf[$];
      logic [7:0] c;
      int         elen;
      int         n;
      int         k;
      elen = (cfg_model.pattern_length > MAX_PAT) ? MAX_PAT : cfg_model.pattern_length;
      n = ($urandom_range(0, 6) == 0) ? $urandom_range(20, 50) : $urandom_range(0, 6);
      for (k = 0; k < n; k++) begin
         line_buf.push_back(noise_byte(elen));
      end
      if (elen > 0 && $urandom_range(0, 9) < 7) begin
         for (k = 0; k < elen; k++) begin
            c = pat_bytes[k];
            if (cfg_model.ignore_case && $urandom_range(0, 1) == 1 &&
                ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z"))) begin
               c = c ^ 8'h20;
            end
            line_buf.push_back(c);
         end
         if ($urandom_range(0, 3) == 0) begin
            line_buf[$urandom_range(line_buf.size() - elen, line_buf.size() - 1)] =
               8'($urandom_range(0, 255));
         end
      end
      n = $urandom_range(0, 6);
      for (k = 0; k < n; k++) begin
         line_buf.push_back(noise_byte(elen));
      end
      if (line_buf.size() == 0) begin
         line_buf.push_back(noise_byte(elen));
      end
      for (k = 0; k < line_buf.size(); k++) begin
         push_byte(line_buf[k], k == line_buf.size() - 1);
      end
      count = line_buf.size();
   endtask

   // -------------------------------------------------------------------------
   // Sender: bursts of random length with random gaps; hold the item until it
   // is taken.
   // -------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (req_bus.valid && !byte_taken) begin
         // hold the current item on the bus
      end else if (gap_left > 0) begin
         gap_left--;
         req_bus.valid <= 1'b0;
      end else if (text_q.size() != 0) begin
         req_bus.valid       <= 1'b1;
         req_bus.char_byte   <= text_q[0].char_byte;
         req_bus.end_of_line <= text_q[0].end_of_line;
         if (burst_left > 0) begin
            burst_left--;
         end else begin
            // pick the next burst; about a third of bursts follow back to back
            burst_left = $urandom_range(1, 30);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         end
      end else begin
         req_bus.valid <= 1'b0;
      end
   end

   // Track accepted bytes and advance the scoreboard with the bus contents.
   always @(posedge clock) begin
      byte_taken = !reset && req_bus.valid && req_bus.ready;
      if (byte_taken) begin
         void'(text_q.pop_front());
         scan_text_byte(req_bus.char_byte, req_bus.end_of_line);
      end
   end

   // -------------------------------------------------------------------------
   // Receiver: stall segments of random length and density, plus a long hold
   // on request so that the result queue backs up into the byte channel.
   // -------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else if (holds_served != hold_requests) begin
         holds_served++;
         hold_left = LONG_HOLD - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         if (stall_left == 0) begin
            stall_left = $urandom_range(1, 40);
            case ($urandom_range(0, 3))
               0:       stall_pct = 0;
               1:       stall_pct = 25;
               2:       stall_pct = 50;
               default: stall_pct = 90;
            endcase
         end
         stall_left--;
         rsp_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // Check each returned verdict against the oldest prediction; drop the run
   // if it outlives the cycle limit.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("line_substring_matcher_tb: errors");
         $finish;
      end else if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (line_verdicts_q.size() == 0) begin
            $error("line_matched: expected no item, got %0b", rsp_bus.line_matched);
            error_count++;
         end else begin
            expected_match = line_verdicts_q.pop_front();
            if (rsp_bus.line_matched !== expected_match) begin
               $error("line_matched: expected %0b, got %0b",
                      expected_match, rsp_bus.line_matched);
               error_count++;
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin
      int               phase;
      int               random_total;
      int               phase_items;
      int               target;
      int               n;
      int               k;
      logic             icase;
      logic [LEN_REG_W-1:0] plen;

      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.char_byte = 8'h00;
      req_bus.end_of_line = 1'b0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.reg_index = CSR_IGNORE_CASE;
      csr_bus.wr_data = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Empty pattern out of reset: every line matches, zero and 0xFF included.
      push_byte(8'h00, 1'b1);
      push_byte(8'hFF, 1'b0);
      push_byte(8'h7F, 1'b1);

      // Writes to unused indexes must leave the registers alone.
      wait_drained();
      write_reg(CSR_SPARE_LO, {WORD_W{1'b1}});
      write_reg(CSR_SPARE_HI, {WORD_W{1'b1}});

      // Fold both sides; a line shorter than the pattern never matches.
      set_pattern("aBc");
      configure(1'b1, 6'd3);
      push_text("xAbC", 1'b1);
      push_text("ab", 1'b1);

      // Without folding, case matters.
      set_pattern("A");
      configure(1'b0, 6'd1);
      push_text("a", 1'b1);
      push_text("A", 1'b1);

      // Fold touches A-Z only: neighbors of the letter range stay apart.
      set_pattern("@[");
      configure(1'b1, 6'd2);
      push_text("@[", 1'b1);
      push_text("`{", 1'b1);
      set_pattern("Zz");
      configure(1'b1, 6'd2);
      push_text("zZ", 1'b1);

      // Zero byte is an ordinary byte in pattern and text.
      set_pattern("");
      pat_bytes[1] = 8'hFF;
      configure(1'b0, 6'd2);
      push_byte(8'h00, 1'b0);
      push_byte(8'hFF, 1'b1);

      // Length beyond the window clamps to the full window.
      set_pattern("");
      configure(1'b0, 6'd63);
      push_byte(8'h00, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'h00, 1'b1);

      // Pattern changes mid-line; later compares see the new pattern.
      set_pattern("zz");
      configure(1'b0, 6'd2);
      push_text("qr", 1'b0);
      wait_drained();
      set_pattern("rs");
      write_reg(CSR_PATTERN_WORD0, pack_word(0));
      push_text("s", 1'b1);

      // Random phases: fresh registers each phase, lines with embedded
      // pattern copies, and sometimes an open line carried into the next phase.
      random_total = 0;
      for (phase = 0; random_total < RANDOM_ITEMS; phase++) begin
         icase = 1'($urandom_range(0, 1));
         case ($urandom_range(0, 7))
            0:       plen = 6'd0;
            1:       plen = 6'd1;
            2:       plen = 6'd32;
            3:       plen = 6'd63;
            4:       plen = 6'($urandom_range(33, 62));
            default: plen = 6'($urandom_range(2, 8));
         endcase
         for (k = 0; k < MAX_PAT; k++) begin
            if ($urandom_range(0, 1) == 1) begin
               pat_bytes[k] = ($urandom_range(0, 1) == 1) ? 8'("A" + $urandom_range(0, 25))
                                                         : 8'("a" + $urandom_range(0, 25));
            end else begin
               pat_bytes[k] = 8'($urandom_range(0, 255));
            end
         end
         configure(icase, plen);

         // Stall the receiver for a long stretch while bytes keep coming.
         if (phase == 3) begin
            hold_requests++;
         end

         phase_items = 0;
         target = $urandom_range(80, 160);
         while (phase_items < target) begin
            queue_random_line(n);
            phase_items += n;
         end
         if ($urandom_range(0, 9) < 3) begin
            n = $urandom_range(1, 5);
            for (k = 0; k < n; k++) begin
               push_byte(noise_byte(plen > MAX_PAT ? MAX_PAT : plen), 1'b0);
            end
            phase_items += n;
         end
         random_total += phase_items;
      end

      // Close any open line so its verdict is checked too.
      push_byte(8'($urandom_range(0, 255)), 1'b1);
      wait_drained();

      if (error_count == 0) begin
         $display("line_substring_matcher_tb: clean");
      end else begin
         $display("line_substring_matcher_tb: errors");
      end
      $finish;
   end

endmodule : line_substring_matcher_tb

// ===== files.f =====
rtl/lsm_pkg.sv
rtl/lsm_req_if.sv
rtl/lsm_rsp_if.sv
rtl/lsm_csr_if.sv
rtl/lsm_csr.sv
rtl/lsm_front.sv
rtl/lsm_queue.sv
rtl/lsm_back.sv
rtl/line_substring_matcher.sv
test/line_substring_matcher_tb.sv
